// ----- hdl/lion_optimizer_update_assert.svh -----
// ----------------------------------------------------------------------------
// lion optimizer update assertion macros
// shared property forms for the update block checks
// ----------------------------------------------------------------------------
`ifndef LION_OPTIMIZER_UPDATE_ASSERT_SVH
`define LION_OPTIMIZER_UPDATE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define LION_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LION_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lion_pkg.sv -----
// ----------------------------------------------------------------------------
// lion_pkg
// shared types and constants of the lion optimizer update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lion_pkg;

  localparam int unsigned LATENCY   = 5;
  localparam int unsigned PROD_W    = 50;
  localparam int unsigned SUM_W     = 51;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic [31:0] LEARN_RATE_RST     = 32'd429497;
  localparam logic [16:0] DIRECTION_BETA_RST = 17'd58982;
  localparam logic [16:0] MOMENTUM_BETA_RST  = 17'd64880;
  localparam logic [31:0] DECAY_RATE_RST     = 32'd0;

  // sign of the direction as a q8.24 step
  localparam logic signed [33:0] SIGN_ONE_Q24 = 34'sd16777216;

  // round-to-nearest bias for a 32-bit shift
  localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;

  localparam logic signed [31:0] Q824_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q824_MIN = 32'sh8000_0000;

  typedef logic signed [31:0] q824_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE     = 2'd0,
    CFG_DIRECTION_BETA = 2'd1,
    CFG_MOMENTUM_BETA  = 2'd2,
    CFG_DECAY_RATE     = 2'd3
  } cfg_index_t;

  // first-stage products handed to both result paths
  typedef struct packed {
    logic signed [PROD_W-1:0] dir_m;
    logic signed [PROD_W-1:0] dir_g;
    logic signed [PROD_W-1:0] mom_m;
    logic signed [PROD_W-1:0] mom_g;
    logic [63:0]              decay;
    q824_t                    weight;
  } prod_t;

  typedef struct packed {
    q824_t value;
    logic  clipped;
  } sat_out_t;

endpackage

`default_nettype wire

// ----- hdl/lion_optimizer_update.sv -----
// ----------------------------------------------------------------------------
// lion_optimizer_update
// element-wise lion optimizer update, five-stage pipeline
// ----------------------------------------------------------------------------
// usage:
//   an item (weight, gradient, momentum, all signed q8.24) is taken at a
//   rising edge with start high and busy low. busy is low except during rst,
//   so one item can enter every cycle, back to back, indefinitely.
//   each result (new_weight, new_momentum, saturated) appears on the ports
//   for one cycle with done high; results leave in item order. throughput
//   is one item per cycle, set by the five registered stages: products,
//   sign/decay, step magnitude, lr multiply, round/saturate. the receiver
//   cannot stall, so nothing is ever held back.
//   the config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   learn_rate, direction_beta, momentum_beta, decay_rate; cfg_ready is
//   always high. betas above one are stored as one. write config only when
//   no item is in flight.
//   synchronous rst empties the pipeline and restores register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lion_optimizer_update (
  input  logic                 clk,
  input  logic                 rst,
  // item channel
  input  logic                 start,
  output logic                 busy,
  input  lion_pkg::q824_t      weight,
  input  lion_pkg::q824_t      gradient,
  input  lion_pkg::q824_t      momentum,
  // config channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  lion_pkg::cfg_index_t cfg_index,
  input  logic [31:0]          cfg_data,
  // result channel
  output logic                 done,
  output lion_pkg::q824_t      new_weight,
  output lion_pkg::q824_t      new_momentum,
  output logic                 saturated
);
  import lion_pkg::*;

`include "lion_optimizer_update_assert.svh"

  logic [31:0]        learn_rate;
  logic [16:0]        b1;
  logic [16:0]        b2;
  logic [31:0]        decay_rate;
  logic [16:0]        beta_in;
  logic [16:0]        beta_clamped;
  logic [LATENCY-1:0] vld;
  logic               accept;
  prod_t              prod;
  sat_out_t           w_out;
  sat_out_t           m_out;

  // the pipeline never backs up; only reset holds items off
  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // betas above one behave as one, so clamp on the write
  assign beta_in      = cfg_data[16:0];
  assign beta_clamped = (beta_in > ONE_Q16) ? ONE_Q16 : beta_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= LEARN_RATE_RST;
      b1         <= DIRECTION_BETA_RST;
      b2         <= MOMENTUM_BETA_RST;
      decay_rate <= DECAY_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEARN_RATE:     learn_rate <= cfg_data;
        CFG_DIRECTION_BETA: b1         <= beta_clamped;
        CFG_MOMENTUM_BETA:  b2         <= beta_clamped;
        CFG_DECAY_RATE:     decay_rate <= cfg_data;
        default:            learn_rate <= learn_rate;
      endcase
    end
  end

  // item valid bits travel alongside the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  // stage 1: all multiplies that only need the raw inputs
  lion_prod u_prod (
    .clk        (clk),
    .weight     (weight),
    .gradient   (gradient),
    .momentum   (momentum),
    .b1         (b1),
    .b2         (b2),
    .decay_rate (decay_rate),
    .prod       (prod)
  );

  // stages 2-5: weight update
  lion_wpath u_wpath (
    .clk        (clk),
    .prod       (prod),
    .learn_rate (learn_rate),
    .result     (w_out)
  );

  // stages 2-5: momentum update
  lion_mpath u_mpath (
    .clk    (clk),
    .prod   (prod),
    .result (m_out)
  );

  assign done         = vld[LATENCY-1];
  assign new_weight   = w_out.value;
  assign new_momentum = m_out.value;
  assign saturated    = w_out.clipped || m_out.clipped;

  // every result traces back to an accepted item
  `LION_ASSERT_IMP(a_latency, done, $past(accept, 5), "result without a matching item")
  // saturation flag only with a result pinned at a range limit
  `LION_ASSERT_IMP(a_sat_limit, done && saturated,
    new_weight == Q824_MAX || new_weight == Q824_MIN ||
    new_momentum == Q824_MAX || new_momentum == Q824_MIN,
    "saturated set with no result at a limit")
  // stored betas never exceed one
  `LION_ASSERT_NEXT(a_b1_clamp, cfg_valid && cfg_ready && cfg_index == CFG_DIRECTION_BETA,
    b1 <= ONE_Q16, "direction beta stored above one")
  `LION_ASSERT_NEXT(a_b2_clamp, cfg_valid && cfg_ready && cfg_index == CFG_MOMENTUM_BETA,
    b2 <= ONE_Q16, "momentum beta stored above one")

endmodule

`default_nettype wire

// ----- hdl/lion_prod.sv -----
// ----------------------------------------------------------------------------
// lion_prod
// first pipeline stage: beta, momentum and decay products, registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lion_prod (
  input  logic            clk,
  input  lion_pkg::q824_t weight,
  input  lion_pkg::q824_t gradient,
  input  lion_pkg::q824_t momentum,
  input  logic [16:0]     b1,
  input  logic [16:0]     b2,
  input  logic [31:0]     decay_rate,
  output lion_pkg::prod_t prod
);
  import lion_pkg::*;

  logic signed [17:0]       b1_s;
  logic signed [17:0]       b1c_s;
  logic signed [17:0]       b2_s;
  logic signed [17:0]       b2c_s;
  logic [16:0]              b1c;
  logic [16:0]              b2c;
  logic [31:0]              w_mag;
  logic signed [PROD_W-1:0] p_dir_m;
  logic signed [PROD_W-1:0] p_dir_g;
  logic signed [PROD_W-1:0] p_mom_m;
  logic signed [PROD_W-1:0] p_mom_g;
  logic [63:0]              p_decay;

  assign b1c   = ONE_Q16 - b1;
  assign b2c   = ONE_Q16 - b2;
  assign b1_s  = $signed({1'b0, b1});
  assign b1c_s = $signed({1'b0, b1c});
  assign b2_s  = $signed({1'b0, b2});
  assign b2c_s = $signed({1'b0, b2c});

  // magnitude of the most negative weight is 2^31, still fits unsigned
  assign w_mag = weight[31] ? (32'd0 - 32'(weight)) : 32'(weight);

  assign p_dir_m = b1_s * momentum;
  assign p_dir_g = b1c_s * gradient;
  assign p_mom_m = b2_s * momentum;
  assign p_mom_g = b2c_s * gradient;
  assign p_decay = decay_rate * w_mag;

  always_ff @(posedge clk) begin
    prod.dir_m  <= p_dir_m;
    prod.dir_g  <= p_dir_g;
    prod.mom_m  <= p_mom_m;
    prod.mom_g  <= p_mom_g;
    prod.decay  <= p_decay;
    prod.weight <= weight;
  end

endmodule

`default_nettype wire

// ----- hdl/lion_wpath.sv -----
// ----------------------------------------------------------------------------
// lion_wpath
// weight path, stages two to five: sign, decay, lr scaling, saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lion_wpath (
  input  logic               clk,
  input  lion_pkg::prod_t    prod,
  input  logic [31:0]        learn_rate,
  output lion_pkg::sat_out_t result
);
  import lion_pkg::*;

  // stage 2
  logic signed [SUM_W-1:0] dir_sum;
  logic [63:0]             t_round;
  logic                    s2_pos;
  logic                    s2_neg;
  logic [31:0]             s2_tmag;
  q824_t                   s2_w;
  // stage 3
  logic signed [33:0]      t_s;
  logic signed [33:0]      sgn;
  logic signed [33:0]      st;
  logic [33:0]             st_abs;
  logic                    s3_neg;
  logic [31:0]             s3_mag;
  q824_t                   s3_w;
  // stage 4
  logic [63:0]             s4_prod;
  logic                    s4_neg;
  q824_t                   s4_w;
  // stage 5
  logic [64:0]             d_round;
  logic [32:0]             d_mag;
  logic signed [34:0]      delta;
  logic signed [34:0]      diff;
  logic                    clip_hi;
  logic                    clip_lo;

  // direction sign and rounded decay magnitude
  assign dir_sum = prod.dir_m + prod.dir_g;
  assign t_round = prod.decay + HALF_Q32;

  always_ff @(posedge clk) begin
    s2_pos  <= !dir_sum[SUM_W-1] && (|dir_sum);
    s2_neg  <= dir_sum[SUM_W-1];
    s2_tmag <= t_round[63:32];
    s2_w    <= prod.weight;
  end

  // step = sign + signed decay term, kept as magnitude and sign
  assign t_s    = s2_w[31] ? -$signed({2'b00, s2_tmag}) : $signed({2'b00, s2_tmag});
  assign sgn    = s2_pos ? SIGN_ONE_Q24 : (s2_neg ? -SIGN_ONE_Q24 : 34'sd0);
  assign st     = sgn + t_s;
  assign st_abs = st[33] ? 34'(-st) : 34'(st);

  always_ff @(posedge clk) begin
    s3_neg <= st[33];
    s3_mag <= st_abs[31:0];
    s3_w   <= s2_w;
  end

  always_ff @(posedge clk) begin
    s4_prod <= learn_rate * s3_mag;
    s4_neg  <= s3_neg;
    s4_w    <= s3_w;
  end

  // round lr * step, subtract, clip to q8.24
  assign d_round = {1'b0, s4_prod} + {1'b0, HALF_Q32};
  assign d_mag   = d_round[64:32];
  assign delta   = s4_neg ? -$signed({2'b00, d_mag}) : $signed({2'b00, d_mag});
  assign diff    = {{3{s4_w[31]}}, s4_w} - delta;
  assign clip_hi = !diff[34] && (|diff[33:31]);
  assign clip_lo = diff[34] && !(&diff[33:31]);

  always_ff @(posedge clk) begin
    result.clipped <= clip_hi || clip_lo;
    if (clip_hi) begin
      result.value <= Q824_MAX;
    end else if (clip_lo) begin
      result.value <= Q824_MIN;
    end else begin
      result.value <= diff[31:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lion_mpath.sv -----
// ----------------------------------------------------------------------------
// lion_mpath
// momentum path, stages two to five: blend sum, rounding, saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lion_mpath (
  input  logic               clk,
  input  lion_pkg::prod_t    prod,
  output lion_pkg::sat_out_t result
);
  import lion_pkg::*;

  logic signed [SUM_W-1:0] s2_sum;
  logic signed [SUM_W-1:0] biased;
  logic signed [SUM_W-1:0] bias;
  logic signed [34:0]      s3_r;
  logic                    clip_hi;
  logic                    clip_lo;
  sat_out_t                s4_out;

  always_ff @(posedge clk) begin
    s2_sum <= prod.mom_m + prod.mom_g;
  end

  // ties away from zero: half for positive, half minus one for negative,
  // then an arithmetic shift
  assign bias   = s2_sum[SUM_W-1] ? SUM_W'(32767) : SUM_W'(32768);
  assign biased = s2_sum + bias;

  always_ff @(posedge clk) begin
    s3_r <= 35'(biased >>> 16);
  end

  assign clip_hi = !s3_r[34] && (|s3_r[33:31]);
  assign clip_lo = s3_r[34] && !(&s3_r[33:31]);

  always_ff @(posedge clk) begin
    s4_out.clipped <= clip_hi || clip_lo;
    if (clip_hi) begin
      s4_out.value <= Q824_MAX;
    end else if (clip_lo) begin
      s4_out.value <= Q824_MIN;
    end else begin
      s4_out.value <= s3_r[31:0];
    end
  end

  // align with the five-stage weight path
  always_ff @(posedge clk) begin
    result <= s4_out;
  end

endmodule

`default_nettype wire
